// ----- hdl/iomlk_pkg.sv -----
// ============================================================================
// Interval offset map lookup - shared package
// Widths, request and status codes, and the token that walks the span chain.
// ============================================================================
package iomlk_pkg;

    localparam int KEY_BITS      = 40;
    localparam int OUT_BITS      = KEY_BITS + 1;
    localparam int DEF_MAX_SPANS = 64;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_LOOKUP = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_CLEARED = 2'd2
    } t_status;

    // Partial lookup result carried from one cell to the next.
    typedef struct packed {
        logic                valid;
        logic [KEY_BITS-1:0] key;
        logic                hit;
        logic [OUT_BITS-1:0] value;
        logic [OUT_BITS-1:0] run;
        logic                have_next;
        logic [KEY_BITS-1:0] nearest;
    } t_token;

endpackage

// ----- hdl/iomlk_if.sv -----
// ============================================================================
// Interval offset map lookup - channel interfaces
// Valid/ready channels for request items and result items.
// ============================================================================
interface iomlk_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    req_type;
    logic [iomlk_pkg::KEY_BITS-1:0] dest_start;
    logic [iomlk_pkg::KEY_BITS-1:0] source_start;
    logic [iomlk_pkg::KEY_BITS-1:0] span_length;
    logic [iomlk_pkg::KEY_BITS-1:0] lookup_key;

    modport source (
        output valid, req_type, dest_start, source_start, span_length, lookup_key,
        input  ready
    );
    modport sink (
        input  valid, req_type, dest_start, source_start, span_length, lookup_key,
        output ready
    );
endinterface

interface iomlk_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [iomlk_pkg::OUT_BITS-1:0] mapped_value;
    logic [iomlk_pkg::OUT_BITS-1:0] remaining_run;
    logic                          span_hit;
    logic                          no_following_span;
    logic [1:0]                    status;

    modport source (
        output valid, mapped_value, remaining_run, span_hit, no_following_span, status,
        input  ready
    );
    modport sink (
        input  valid, mapped_value, remaining_run, span_hit, no_following_span, status,
        output ready
    );
endinterface

// ----- hdl/iomlk_cell.sv -----
// ============================================================================
// Interval offset map lookup - span cell
// Holds one span and folds it into the lookup token passing through.
// ============================================================================
module iomlk_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [CNT_W-1:0]               i_count,
    input  logic                           i_wr_en,
    input  logic [iomlk_pkg::KEY_BITS-1:0] i_dest,
    input  logic [iomlk_pkg::KEY_BITS-1:0] i_src,
    input  logic [iomlk_pkg::KEY_BITS-1:0] i_len,
    input  iomlk_pkg::t_token              i_tok,
    output iomlk_pkg::t_token              o_tok
);

    // The span is kept as source start, end and destination offset so that
    // a lookup needs only compares and one add per field.
    logic [iomlk_pkg::KEY_BITS-1:0] r_src;
    logic [iomlk_pkg::OUT_BITS-1:0] r_end;
    logic [iomlk_pkg::OUT_BITS-1:0] r_off;
    iomlk_pkg::t_token              r_tok;
    iomlk_pkg::t_token              n_tok;

    logic                           w_live;
    logic [iomlk_pkg::OUT_BITS-1:0] w_key_x;
    logic                           w_in_span;
    logic                           w_above;
    logic [iomlk_pkg::KEY_BITS-1:0] w_dist;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_src <= i_src;
            r_end <= {1'b0, i_src} + {1'b0, i_len};
            r_off <= {1'b0, i_dest} - {1'b0, i_src};
        end
    end

    always_comb begin
        w_live    = (CNT_W'(IDX) < i_count) && !i_tok.hit;
        w_key_x   = {1'b0, i_tok.key};
        w_in_span = w_live && (i_tok.key >= r_src) && (w_key_x < r_end);
        w_above   = w_live && (i_tok.key < r_src);
        w_dist    = r_src - i_tok.key;

        n_tok = i_tok;
        if (w_in_span) begin
            n_tok.hit   = 1'b1;
            n_tok.value = w_key_x + r_off;
            n_tok.run   = r_end - w_key_x;
        end else if (w_above && (!i_tok.have_next || (w_dist < i_tok.nearest))) begin
            n_tok.have_next = 1'b1;
            n_tok.nearest   = w_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ----- hdl/interval_offset_map_lookup_top.sv -----
// ============================================================================
// Interval offset map lookup - top level
// Ordered span table with first-match key translation and run lengths.
// ============================================================================
// The table is a row of MAX_SPANS cells, one span per cell in insertion order.
// A clear or append request is handled in its accept cycle; its result is
// registered in the finished slot and then moves to the output register. A
// lookup sends a token down the row, one cell per cycle; each cell checks its
// own span and keeps the first hit or the nearest span start above the key.
// The token leaving the last cell becomes a result on the same path. One
// request is in flight at a time: the next request is taken once the previous
// result has moved into the output register, even if that result is still
// waiting to be taken by the sink. The span stores need no clearing after
// reset; the span count alone decides which cells take part.
module interval_offset_map_lookup_top #(
    parameter int MAX_SPANS = iomlk_pkg::DEF_MAX_SPANS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    iomlk_req_if.sink   i_req,
    iomlk_rsp_if.source o_rsp
);

    localparam int CNT_W = $clog2(MAX_SPANS + 1);

    typedef struct packed {
        logic [iomlk_pkg::OUT_BITS-1:0] mapped_value;
        logic [iomlk_pkg::OUT_BITS-1:0] remaining_run;
        logic                           span_hit;
        logic                           no_following_span;
        iomlk_pkg::t_status             status;
    } t_result;

    logic [CNT_W-1:0]  r_count;
    logic              r_look;
    logic              r_fin_valid;
    t_result           r_fin;
    logic              r_out_valid;
    t_result           r_out;

    logic              w_accept;
    logic              w_full;
    logic              w_append;
    logic              w_fin_move;
    t_result           w_imm;
    t_result           w_exit_res;
    iomlk_pkg::t_token w_tok [MAX_SPANS+1];
    logic [MAX_SPANS-1:0] w_tok_valid;

    // Accept only with no lookup in the row and the finished slot empty.
    assign i_req.ready = !r_look && !r_fin_valid;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = (r_count >= CNT_W'(MAX_SPANS));

    // Immediate result for every request other than a lookup.
    always_comb begin
        w_imm    = '0;
        w_append = 1'b0;
        unique case (iomlk_pkg::t_req'(i_req.req_type))
            iomlk_pkg::REQ_CLEAR: begin
                w_imm.status = iomlk_pkg::ST_CLEARED;
            end
            iomlk_pkg::REQ_APPEND: begin
                w_imm.status = w_full ? iomlk_pkg::ST_FULL : iomlk_pkg::ST_OK;
                w_append     = !w_full;
            end
            iomlk_pkg::REQ_LOOKUP: begin
                w_imm.status = iomlk_pkg::ST_OK;
            end
            default: begin
                w_imm.status = iomlk_pkg::ST_OK;
            end
        endcase
    end

    // The token enters the first cell straight from the request payload.
    always_comb begin
        w_tok[0]       = '0;
        w_tok[0].valid = w_accept &&
                         (iomlk_pkg::t_req'(i_req.req_type) == iomlk_pkg::REQ_LOOKUP);
        w_tok[0].key   = i_req.lookup_key;
    end

    for (genvar g = 0; g < MAX_SPANS; g++) begin : g_cell
        iomlk_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_count (r_count),
            .i_wr_en (w_accept && w_append && (r_count == CNT_W'(g))),
            .i_dest  (i_req.dest_start),
            .i_src   (i_req.source_start),
            .i_len   (i_req.span_length),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
        assign w_tok_valid[g] = w_tok[g+1].valid;
    end

    // Turn the token leaving the last cell into a result. On a miss the key
    // passes through, and the run is either the distance to the nearest span
    // start above the key or saturated when there is none.
    always_comb begin
        w_exit_res        = '0;
        w_exit_res.status = iomlk_pkg::ST_OK;
        if (w_tok[MAX_SPANS].hit) begin
            w_exit_res.mapped_value  = w_tok[MAX_SPANS].value;
            w_exit_res.remaining_run = w_tok[MAX_SPANS].run;
            w_exit_res.span_hit      = 1'b1;
        end else begin
            w_exit_res.mapped_value = {1'b0, w_tok[MAX_SPANS].key};
            if (w_tok[MAX_SPANS].have_next) begin
                w_exit_res.remaining_run = {1'b0, w_tok[MAX_SPANS].nearest};
            end else begin
                w_exit_res.remaining_run     = '1;
                w_exit_res.no_following_span = 1'b1;
            end
        end
    end

    assign w_fin_move = r_fin_valid && (!r_out_valid || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (w_accept && !w_tok[0].valid) begin
            r_fin <= w_imm;
        end else if (w_tok[MAX_SPANS].valid) begin
            r_fin <= w_exit_res;
        end
        if (w_fin_move) begin
            r_out <= r_fin;
        end

        if (!i_rst_n) begin
            r_count     <= '0;
            r_look      <= 1'b0;
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept &&
                (iomlk_pkg::t_req'(i_req.req_type) == iomlk_pkg::REQ_CLEAR)) begin
                r_count <= '0;
            end else if (w_accept && w_append) begin
                r_count <= r_count + CNT_W'(1);
            end

            if (w_tok[0].valid) begin
                r_look <= 1'b1;
            end else if (w_tok[MAX_SPANS].valid) begin
                r_look <= 1'b0;
            end

            if ((w_accept && !w_tok[0].valid) || w_tok[MAX_SPANS].valid) begin
                r_fin_valid <= 1'b1;
            end else if (w_fin_move) begin
                r_fin_valid <= 1'b0;
            end

            if (w_fin_move) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.mapped_value      = r_out.mapped_value;
    assign o_rsp.remaining_run     = r_out.remaining_run;
    assign o_rsp.span_hit          = r_out.span_hit;
    assign o_rsp.no_following_span = r_out.no_following_span;
    assign o_rsp.status            = r_out.status;

    // At most one lookup token travels down the row.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_tok_valid) <= 1)
        else $error("more than one lookup token in the cell row");

    // A token can leave the row only while a lookup is marked in flight.
    a_exit_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[MAX_SPANS].valid |-> r_look)
        else $error("lookup token left the row with no lookup in flight");

    // The span count never exceeds the table size.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SPANS))
        else $error("span count beyond table size");

    // A finished result is never dropped before it moves to the output.
    a_fin_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_valid && !w_fin_move |=> r_fin_valid)
        else $error("finished result lost");

    // A hit never claims that no span follows.
    a_hit_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.span_hit |-> !r_out.no_following_span)
        else $error("hit and no-following-span both set");

endmodule
